### design/gbfs_pkg.sv
package gbfs_pkg;

    localparam int DEF_NODE_COUNT = 32;
    localparam int DEF_EDGE_CAP   = 256;
    localparam int ID_W           = 5;
    localparam int HEUR_W         = 16;
    localparam int WEIGHT_W       = 16;
    localparam int COST_W         = 32;
    localparam int CNT_W          = 2;

    typedef enum logic [1:0] {
        REQ_HEUR   = 2'd0,
        REQ_EDGE   = 2'd1,
        REQ_SEARCH = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        KIND_PATH   = 2'd0,
        KIND_NOPATH = 2'd1,
        KIND_COUNT  = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_EDGE_A,
        S_EDGE_B,
        S_INIT,
        S_CHECK,
        S_SCAN,
        S_MOVE,
        S_EXPAND,
        S_EXP2,
        S_EPROC,
        S_RESULT,
        S_TRACE,
        S_PATH,
        S_NOPATH,
        S_CNT
    } t_state;

    typedef struct packed {
        logic  latch_req;
        logic  heur_wr;
        logic  edge_wr_a;
        logic  edge_wr_b;
        logic  init;
        logic  q_rd_first;
        logic  q_scan;
        logic  q_move;
        logic  expand;
        logic  cur_cost_latch;
        logic  edge_rd_head;
        logic  edge_proc;
        logic  cost_rd_goal;
        logic  trace_init;
        logic  trace_step;
        logic  emit;
        t_kind emit_kind;
        logic  path_pop;
        logic  cnt_step;
    } t_cmd;

    typedef struct packed {
        t_req req;
        logic edge_ok;
        logic start_ok;
        logic scan_more;
        logic q_empty;
        logic cur_is_goal;
        logic head_valid;
        logic edge_end;
        logic goal_reached;
        logic trace_done;
        logic path_last;
        logic out_busy;
        logic cnt_nonzero;
        logic cnt_last_idx;
    } t_status;

endpackage

### design/gbfs_ctrl.sv
module gbfs_ctrl
    import gbfs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.emit_kind = KIND_PATH;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.latch_req = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_status.req)
                    REQ_HEUR: begin
                        o_cmd.heur_wr = 1'b1;
                        n_state = S_IDLE;
                    end
                    REQ_EDGE:   n_state = i_status.edge_ok ? S_EDGE_A : S_IDLE;
                    REQ_SEARCH: n_state = S_INIT;
                    default:    n_state = S_IDLE;
                endcase
            end
            S_EDGE_A: begin
                o_cmd.edge_wr_a = 1'b1;
                n_state = S_EDGE_B;
            end
            S_EDGE_B: begin
                o_cmd.edge_wr_b = 1'b1;
                n_state = S_IDLE;
            end
            S_INIT: begin
                o_cmd.init = 1'b1;
                n_state = i_status.start_ok ? S_CHECK : S_NOPATH;
            end
            S_CHECK: begin
                if (i_status.q_empty) begin
                    n_state = S_RESULT;
                end else begin
                    o_cmd.q_rd_first = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.q_scan = 1'b1;
                if (!i_status.scan_more) begin
                    n_state = S_MOVE;
                end
            end
            S_MOVE: begin
                o_cmd.q_move = 1'b1;
                n_state = S_EXPAND;
            end
            S_EXPAND: begin
                o_cmd.expand = 1'b1;
                n_state = i_status.cur_is_goal ? S_RESULT : S_EXP2;
            end
            S_EXP2: begin
                o_cmd.cur_cost_latch = 1'b1;
                if (i_status.head_valid) begin
                    o_cmd.edge_rd_head = 1'b1;
                    n_state = S_EPROC;
                end else begin
                    n_state = S_CHECK;
                end
            end
            S_EPROC: begin
                o_cmd.edge_proc = 1'b1;
                if (i_status.edge_end) begin
                    n_state = S_CHECK;
                end
            end
            S_RESULT: begin
                o_cmd.cost_rd_goal = 1'b1;
                o_cmd.trace_init   = 1'b1;
                n_state = i_status.goal_reached ? S_TRACE : S_NOPATH;
            end
            S_TRACE: begin
                o_cmd.cost_rd_goal = 1'b1;
                o_cmd.trace_step   = 1'b1;
                if (i_status.trace_done) begin
                    n_state = S_PATH;
                end
            end
            S_PATH: begin
                if (!i_status.out_busy) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = KIND_PATH;
                    o_cmd.path_pop  = 1'b1;
                    if (i_status.path_last) begin
                        n_state = S_CNT;
                    end
                end
            end
            S_NOPATH: begin
                if (!i_status.out_busy) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = KIND_NOPATH;
                    n_state = i_status.start_ok ? S_CNT : S_IDLE;
                end
            end
            S_CNT: begin
                if (!i_status.cnt_nonzero || !i_status.out_busy) begin
                    o_cmd.cnt_step = 1'b1;
                    if (i_status.cnt_nonzero) begin
                        o_cmd.emit      = 1'b1;
                        o_cmd.emit_kind = KIND_COUNT;
                    end
                    if (i_status.cnt_last_idx) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

### design/gbfs_dp.sv
module gbfs_dp
    import gbfs_pkg::*;
#(
    parameter int NODE_COUNT = DEF_NODE_COUNT,
    parameter int EDGE_CAP   = DEF_EDGE_CAP
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [1:0]                 i_req_type,
    input  logic [ID_W-1:0]            i_vertex_id,
    input  logic signed [HEUR_W-1:0]   i_heuristic_value,
    input  logic [ID_W-1:0]            i_edge_from,
    input  logic [ID_W-1:0]            i_edge_to,
    input  logic signed [WEIGHT_W-1:0] i_edge_cost,
    input  logic [ID_W-1:0]            i_start_node,
    input  logic [ID_W-1:0]            i_goal_node,
    input  logic                       i_ready,
    input  t_cmd                       i_cmd,
    output t_status                    o_status,
    output logic                       o_valid,
    output logic [1:0]                 o_item_kind,
    output logic [ID_W-1:0]            o_node_ref,
    output logic signed [COST_W-1:0]   o_path_cost,
    output logic [CNT_W-1:0]           o_expand_count,
    output logic                       o_last_item
);

    localparam int NW  = $clog2(NODE_COUNT);
    localparam int LW  = NW + 1;
    localparam int EW  = (EDGE_CAP > 1) ? $clog2(EDGE_CAP) : 1;
    localparam int CW  = $clog2(EDGE_CAP + 1);
    localparam int QD  = NODE_COUNT + 1;
    localparam int QIW = $clog2(QD);
    localparam int QW  = $clog2(QD + 1);

    // latched request
    t_req                       r_req;
    logic [ID_W-1:0]            r_vid, r_ef, r_et, r_start, r_goal;
    logic signed [HEUR_W-1:0]   r_hval;
    logic signed [WEIGHT_W-1:0] r_ecost;

    // graph storage
    logic signed [HEUR_W-1:0]   r_heur [NODE_COUNT];
    logic                       r_hv   [NODE_COUNT];
    logic [EW-1:0]              r_head [NODE_COUNT];
    logic [EW-1:0]              r_tail [NODE_COUNT];
    logic [CW-1:0]              r_stored;
    logic [NW-1:0]              m_etgt [EDGE_CAP];
    logic signed [WEIGHT_W-1:0] m_ew   [EDGE_CAP];
    logic                       m_eend [EDGE_CAP];
    logic [EW-1:0]              m_elnk [EDGE_CAP];
    logic [NW-1:0]              r_e_tgt;
    logic signed [WEIGHT_W-1:0] r_e_w;
    logic                       r_e_end;
    logic [EW-1:0]              r_e_lnk;

    // search state
    logic [NW-1:0]              m_qnode [QD];
    logic [QW-1:0]              m_qord  [QD];
    logic signed [HEUR_W-1:0]   m_qheur [QD];
    logic [NW-1:0]              r_q_node;
    logic [QW-1:0]              r_q_ord;
    logic signed [HEUR_W-1:0]   r_q_heur;
    logic [QW-1:0]              r_q_count, r_seq, r_scan;
    logic [QIW-1:0]             r_best_idx;
    logic [NW-1:0]              r_best_node;
    logic [QW-1:0]              r_best_ord;
    logic signed [HEUR_W-1:0]   r_best_heur;
    logic [NW-1:0]              r_cur;
    logic signed [COST_W-1:0]   r_cur_cost;
    logic                       r_pv     [NODE_COUNT];
    logic [NW-1:0]              r_parent [NODE_COUNT];
    logic [CNT_W-1:0]           r_exp    [NODE_COUNT];
    logic signed [COST_W-1:0]   m_cost   [NODE_COUNT];
    logic signed [COST_W-1:0]   r_cost_rd;
    logic [NW-1:0]              r_route  [NODE_COUNT];
    logic [NW-1:0]              r_tcur;
    logic [LW-1:0]              r_len;
    logic signed [COST_W-1:0]   r_path_cost;
    logic [NW-1:0]              r_idx;

    // output register
    logic                       r_out_valid;
    t_kind                      r_o_kind;
    logic [ID_W-1:0]            r_o_node;
    logic signed [COST_W-1:0]   r_o_cost;
    logic [CNT_W-1:0]           r_o_cnt;
    logic                       r_o_last;

    logic [NW-1:0]  vid_n, ef_n, et_n, start_n, goal_n;
    logic           vertex_ok, edge_ok, start_ok, goal_ok;
    logic [EW-1:0]  new_e;
    logic           scan_more, take;
    logic [QW-1:0]  scan_nxt, last_q;
    logic [QIW-1:0] q_raddr;
    logic           q_we;
    logic [QIW-1:0] q_waddr;
    logic [NW-1:0]  q_wnode;
    logic [QW-1:0]  q_word;
    logic signed [HEUR_W-1:0] q_wheur;
    logic           push_ok;
    logic signed [COST_W:0]   sum_w;
    logic signed [COST_W-1:0] sum_sat;
    logic           cost_we;
    logic [NW-1:0]  cost_waddr, cost_raddr;
    logic signed [COST_W-1:0] cost_wdata;
    logic           e_rd;
    logic [EW-1:0]  e_raddr;
    logic           trace_done;
    logic           more_after;

    assign vid_n   = r_vid[NW-1:0];
    assign ef_n    = r_ef[NW-1:0];
    assign et_n    = r_et[NW-1:0];
    assign start_n = r_start[NW-1:0];
    assign goal_n  = r_goal[NW-1:0];

    assign vertex_ok = {1'b0, r_vid}   < (ID_W+1)'(NODE_COUNT);
    assign start_ok  = {1'b0, r_start} < (ID_W+1)'(NODE_COUNT);
    assign goal_ok   = {1'b0, r_goal}  < (ID_W+1)'(NODE_COUNT);
    assign edge_ok   = ({1'b0, r_ef} < (ID_W+1)'(NODE_COUNT))
                    && ({1'b0, r_et} < (ID_W+1)'(NODE_COUNT))
                    && (r_stored < CW'(EDGE_CAP));
    assign new_e     = r_stored[EW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_req) begin
            r_req   <= t_req'(i_req_type);
            r_vid   <= i_vertex_id;
            r_hval  <= i_heuristic_value;
            r_ef    <= i_edge_from;
            r_et    <= i_edge_to;
            r_ecost <= i_edge_cost;
            r_start <= i_start_node;
            r_goal  <= i_goal_node;
        end
    end

    // heuristics, list heads and edge count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NODE_COUNT; i++) begin
                r_heur[i] <= '0;
                r_hv[i]   <= 1'b0;
            end
            r_stored <= '0;
        end else begin
            if (i_cmd.heur_wr && vertex_ok) begin
                r_heur[vid_n] <= r_hval;
            end
            if (i_cmd.edge_wr_b) begin
                if (!r_hv[ef_n]) begin
                    r_hv[ef_n]   <= 1'b1;
                    r_head[ef_n] <= new_e;
                end
                r_tail[ef_n] <= new_e;
                r_stored     <= r_stored + CW'(1);
            end
        end
    end

    // edge store: new edge first, then link from the old tail
    assign e_rd    = i_cmd.edge_rd_head || (i_cmd.edge_proc && !r_e_end);
    assign e_raddr = i_cmd.edge_rd_head ? r_head[r_cur] : r_e_lnk;

    always_ff @(posedge i_clk) begin
        if (i_cmd.edge_wr_a) begin
            m_etgt[new_e] <= et_n;
            m_ew[new_e]   <= r_ecost;
            m_eend[new_e] <= 1'b1;
        end
        if (i_cmd.edge_wr_b && r_hv[ef_n]) begin
            m_eend[r_tail[ef_n]] <= 1'b0;
            m_elnk[r_tail[ef_n]] <= new_e;
        end
        if (e_rd) begin
            r_e_tgt <= m_etgt[e_raddr];
            r_e_w   <= m_ew[e_raddr];
            r_e_end <= m_eend[e_raddr];
            r_e_lnk <= m_elnk[e_raddr];
        end
    end

    // pending queue, scanned one entry a cycle
    assign scan_nxt  = r_scan + QW'(1);
    assign scan_more = scan_nxt < r_q_count;
    assign last_q    = r_q_count - QW'(1);
    assign take      = (r_scan == '0) || (r_q_heur < r_best_heur)
                    || ((r_q_heur == r_best_heur) && (r_q_ord < r_best_ord));
    assign push_ok   = i_cmd.edge_proc && !r_pv[r_e_tgt] && (r_q_count < QW'(QD));

    always_comb begin
        if (i_cmd.q_rd_first) begin
            q_raddr = '0;
        end else if (i_cmd.q_scan && scan_more) begin
            q_raddr = scan_nxt[QIW-1:0];
        end else begin
            q_raddr = last_q[QIW-1:0];
        end
        q_we    = 1'b0;
        q_waddr = r_q_count[QIW-1:0];
        q_wnode = r_e_tgt;
        q_word  = r_seq;
        q_wheur = r_heur[r_e_tgt];
        if (i_cmd.init) begin
            q_we    = start_ok;
            q_waddr = '0;
            q_wnode = start_n;
            q_word  = '0;
            q_wheur = r_heur[start_n];
        end else if (i_cmd.q_move) begin
            q_we    = 1'b1;
            q_waddr = r_best_idx;
            q_wnode = r_q_node;
            q_word  = r_q_ord;
            q_wheur = r_q_heur;
        end else if (push_ok) begin
            q_we    = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_we) begin
            m_qnode[q_waddr] <= q_wnode;
            m_qord[q_waddr]  <= q_word;
            m_qheur[q_waddr] <= q_wheur;
        end
        r_q_node <= m_qnode[q_raddr];
        r_q_ord  <= m_qord[q_raddr];
        r_q_heur <= m_qheur[q_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_count <= '0;
            r_seq     <= '0;
        end else begin
            if (i_cmd.init) begin
                r_q_count <= start_ok ? QW'(1) : '0;
                r_seq     <= QW'(1);
            end else if (i_cmd.q_move) begin
                r_q_count <= last_q;
            end else if (push_ok) begin
                r_q_count <= r_q_count + QW'(1);
                r_seq     <= r_seq + QW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.q_rd_first) begin
            r_scan <= '0;
        end else if (i_cmd.q_scan && scan_more) begin
            r_scan <= scan_nxt;
        end
        if (i_cmd.q_scan && take) begin
            r_best_idx  <= r_scan[QIW-1:0];
            r_best_node <= r_q_node;
            r_best_ord  <= r_q_ord;
            r_best_heur <= r_q_heur;
        end
        if (i_cmd.q_move) begin
            r_cur <= r_best_node;
        end
        if (i_cmd.cur_cost_latch) begin
            r_cur_cost <= r_cost_rd;
        end else if (push_ok && (r_e_tgt == r_cur)) begin
            // a self loop on the start node changes its cost for the later edges
            r_cur_cost <= sum_sat;
        end
    end

    // saturating cost of a successor
    assign sum_w = {r_cur_cost[COST_W-1], r_cur_cost}
                 + {{(COST_W+1-WEIGHT_W){r_e_w[WEIGHT_W-1]}}, r_e_w};
    always_comb begin
        if (sum_w[COST_W] != sum_w[COST_W-1]) begin
            sum_sat = sum_w[COST_W] ? {1'b1, {(COST_W-1){1'b0}}}
                                    : {1'b0, {(COST_W-1){1'b1}}};
        end else begin
            sum_sat = sum_w[COST_W-1:0];
        end
    end

    assign cost_we    = (i_cmd.init && start_ok) || push_ok;
    assign cost_waddr = i_cmd.init ? start_n : r_e_tgt;
    assign cost_wdata = i_cmd.init ? '0 : sum_sat;
    assign cost_raddr = i_cmd.cost_rd_goal ? goal_n : r_cur;

    always_ff @(posedge i_clk) begin
        if (cost_we) begin
            m_cost[cost_waddr] <= cost_wdata;
        end
        r_cost_rd <= m_cost[cost_raddr];
    end

    // predecessor marks and expansion counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NODE_COUNT; i++) begin
                r_pv[i]  <= 1'b0;
                r_exp[i] <= '0;
            end
        end else if (i_cmd.init) begin
            for (int i = 0; i < NODE_COUNT; i++) begin
                r_pv[i]  <= 1'b0;
                r_exp[i] <= '0;
            end
        end else begin
            if (i_cmd.expand && (r_exp[r_cur] != '1)) begin
                r_exp[r_cur] <= r_exp[r_cur] + CNT_W'(1);
            end
            if (i_cmd.edge_proc && !r_pv[r_e_tgt]) begin
                r_pv[r_e_tgt] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.edge_proc && !r_pv[r_e_tgt]) begin
            r_parent[r_e_tgt] <= r_cur;
        end
    end

    // walk back from the goal into the route buffer
    assign trace_done = (r_tcur == start_n) || (r_len >= LW'(NODE_COUNT - 1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.trace_init) begin
            r_tcur <= goal_n;
            r_len  <= '0;
        end else if (i_cmd.trace_step) begin
            r_path_cost <= r_cost_rd;
            r_len       <= r_len + LW'(1);
            if (trace_done) begin
                r_route[r_len[NW-1:0]] <= start_n;
            end else begin
                r_route[r_len[NW-1:0]] <= r_tcur;
                r_tcur                 <= r_parent[r_tcur];
            end
        end else if (i_cmd.path_pop) begin
            r_len <= r_len - LW'(1);
        end
        if (i_cmd.init) begin
            r_idx <= '0;
        end else if (i_cmd.cnt_step) begin
            r_idx <= r_idx + NW'(1);
        end
    end

    always_comb begin
        more_after = 1'b0;
        for (int i = 0; i < NODE_COUNT; i++) begin
            if ((NW'(i) > r_idx) && (r_exp[i] != '0)) begin
                more_after = 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_kind <= i_cmd.emit_kind;
            unique case (i_cmd.emit_kind)
                KIND_PATH: begin
                    r_o_node <= ID_W'(r_route[r_len[NW-1:0] - NW'(1)]);
                    r_o_cost <= r_path_cost;
                    r_o_cnt  <= '0;
                    r_o_last <= 1'b0;
                end
                KIND_NOPATH: begin
                    r_o_node <= '0;
                    r_o_cost <= '1;
                    r_o_cnt  <= '0;
                    r_o_last <= !start_ok;
                end
                default: begin
                    r_o_node <= ID_W'(r_idx);
                    r_o_cost <= '0;
                    r_o_cnt  <= r_exp[r_idx];
                    r_o_last <= !more_after;
                end
            endcase
        end
    end

    assign o_valid        = r_out_valid;
    assign o_item_kind    = r_o_kind;
    assign o_node_ref     = r_o_node;
    assign o_path_cost    = r_o_cost;
    assign o_expand_count = r_o_cnt;
    assign o_last_item    = r_o_last;

    always_comb begin
        o_status              = '0;
        o_status.req          = r_req;
        o_status.edge_ok      = edge_ok;
        o_status.start_ok     = start_ok;
        o_status.scan_more    = scan_more;
        o_status.q_empty      = (r_q_count == '0);
        o_status.cur_is_goal  = goal_ok && (r_cur == goal_n);
        o_status.head_valid   = r_hv[r_cur];
        o_status.edge_end     = r_e_end;
        o_status.goal_reached = goal_ok && r_pv[goal_n];
        o_status.trace_done   = trace_done;
        o_status.path_last    = (r_len == LW'(1));
        o_status.out_busy     = r_out_valid;
        o_status.cnt_nonzero  = (r_exp[r_idx] != '0);
        o_status.cnt_last_idx = (r_idx == NW'(NODE_COUNT - 1));
    end

`ifndef SYNTHESIS
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> !r_out_valid)
        else $error("result issued over a pending result");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.q_move |-> (r_q_count != '0))
        else $error("pop from empty queue");
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push_ok |=> (r_q_count <= QW'(QD)))
        else $error("queue overflow");
    a_edge_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.edge_wr_b |=> (r_stored <= CW'(EDGE_CAP)))
        else $error("edge store overflow");
`endif

endmodule

### design/greedy_best_first_search.sv
// set and add requests give no result
// search: each pop scans the whole queue, stored edges are walked, the path is
//   traced back from the goal, then counts are given per node; results go out
//   through a single output register
// throughput: one request at a time, next request taken once the search ends
// reset: i_rst_n synchronous active low; heuristics zero, edge lists empty
module greedy_best_first_search
    import gbfs_pkg::*;
#(
    parameter int NODE_COUNT = DEF_NODE_COUNT,
    parameter int EDGE_CAP   = DEF_EDGE_CAP
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [1:0]                 i_req_type,
    input  logic [ID_W-1:0]            i_vertex_id,
    input  logic signed [HEUR_W-1:0]   i_heuristic_value,
    input  logic [ID_W-1:0]            i_edge_from,
    input  logic [ID_W-1:0]            i_edge_to,
    input  logic signed [WEIGHT_W-1:0] i_edge_cost,
    input  logic [ID_W-1:0]            i_start_node,
    input  logic [ID_W-1:0]            i_goal_node,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [1:0]                 o_item_kind,
    output logic [ID_W-1:0]            o_node_ref,
    output logic signed [COST_W-1:0]   o_path_cost,
    output logic [CNT_W-1:0]           o_expand_count,
    output logic                       o_last_item
);

    // controller sequences request decode, queue scan, edge walk,
    // path trace and result emission; datapath holds all storage
    t_cmd    w_cmd;
    t_status w_status;

    gbfs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    // edge walk takes one stored edge per cycle from its registered read
    gbfs_dp #(
        .NODE_COUNT (NODE_COUNT),
        .EDGE_CAP   (EDGE_CAP)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_req_type        (i_req_type),
        .i_vertex_id       (i_vertex_id),
        .i_heuristic_value (i_heuristic_value),
        .i_edge_from       (i_edge_from),
        .i_edge_to         (i_edge_to),
        .i_edge_cost       (i_edge_cost),
        .i_start_node      (i_start_node),
        .i_goal_node       (i_goal_node),
        .i_ready           (i_ready),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .o_valid           (o_valid),
        .o_item_kind       (o_item_kind),
        .o_node_ref        (o_node_ref),
        .o_path_cost       (o_path_cost),
        .o_expand_count    (o_expand_count),
        .o_last_item       (o_last_item)
    );

endmodule

### tb/tb_top.sv
module tb_top;
    import gbfs_pkg::*;

    localparam int NODES = DEF_NODE_COUNT;
    localparam int ECAP  = DEF_EDGE_CAP;
    localparam int NO_LINK = ECAP;

    // one request as offered to the block
    typedef struct {
        t_req                 req;
        logic [ID_W-1:0]      vertex;
        logic [HEUR_W-1:0]    heur;
        logic [ID_W-1:0]      efrom;
        logic [ID_W-1:0]      eto;
        logic [WEIGHT_W-1:0]  ecost;
        logic [ID_W-1:0]      start;
        logic [ID_W-1:0]      goal;
    } t_request;

    // one result item of a search
    typedef struct {
        t_kind                kind;
        logic [ID_W-1:0]      node;
        logic [COST_W-1:0]    cost;
        logic [CNT_W-1:0]     cnt;
        logic                 last;
    } t_result;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_ready;
    logic [1:0]                 i_req_type;
    logic [ID_W-1:0]            i_vertex_id;
    logic signed [HEUR_W-1:0]   i_heuristic_value;
    logic [ID_W-1:0]            i_edge_from;
    logic [ID_W-1:0]            i_edge_to;
    logic signed [WEIGHT_W-1:0] i_edge_cost;
    logic [ID_W-1:0]            i_start_node;
    logic [ID_W-1:0]            i_goal_node;
    logic                       o_valid;
    logic                       i_ready;
    logic [1:0]                 o_item_kind;
    logic [ID_W-1:0]            o_node_ref;
    logic signed [COST_W-1:0]   o_path_cost;
    logic [CNT_W-1:0]           o_expand_count;
    logic                       o_last_item;

    greedy_best_first_search dut (.*);

    // predictor state: graph and per-search scratch
    logic signed [HEUR_W-1:0]   heur_of [NODES];
    logic [ID_W-1:0]            arc_dst [ECAP];
    logic signed [WEIGHT_W-1:0] arc_wt  [ECAP];
    int                         arc_next[ECAP];
    int                         first_arc[NODES];
    int                         last_arc[NODES];
    int                         arc_total;

    t_request pending_reqs[$];
    t_result  expected_results[$];

    int  mismatches;
    int  requests_sent;
    int  results_seen;
    int  searches_sent;
    bit  quiet_phase;
    bit  hold_rx;
    int  rx_gap;
    int  tx_gap;

    function automatic logic signed [31:0] sat_sum(logic signed [31:0] a,
                                                   logic signed [WEIGHT_W-1:0] b);
        longint s;
        s = longint'(a) + longint'(b);
        if (s > 64'sd2147483647) return 32'sh7fffffff;
        if (s < -64'sd2147483648) return 32'sh80000000;
        return s[31:0];
    endfunction

    // appends a request to the stimulus plan
    function automatic void add_req(t_request r);
        pending_reqs = {pending_reqs, r};
    endfunction

    // predicts the block: updates the graph, or runs the search and queues results
    task automatic predict_request(t_request r);
        int        fifo_node[$];
        int        fifo_seq[$];
        int        seqn, best, cur, e, steps, d, k, len;
        bit        has_parent[NODES];
        int        parent[NODES];
        logic signed [31:0] reach[NODES];
        int        expanded[NODES];
        int        route[$];
        t_result   res[$];
        t_result   item;
        case (r.req)
            REQ_HEUR: heur_of[r.vertex] = r.heur;
            REQ_EDGE: begin
                if (arc_total < ECAP) begin
                    arc_dst[arc_total]  = r.eto;
                    arc_wt[arc_total]   = r.ecost;
                    arc_next[arc_total] = NO_LINK;
                    if (first_arc[r.efrom] == NO_LINK) first_arc[r.efrom] = arc_total;
                    else arc_next[last_arc[r.efrom]] = arc_total;
                    last_arc[r.efrom] = arc_total;
                    arc_total++;
                end
            end
            REQ_SEARCH: begin
                seqn = 0;
                foreach (has_parent[i]) begin
                    has_parent[i] = 0;
                    expanded[i] = 0;
                    reach[i] = 0;
                    parent[i] = 0;
                end
                reach[r.start] = 0;
                fifo_node = {fifo_node, int'(r.start)};
                fifo_seq = {fifo_seq, seqn};
                seqn++;
                while (fifo_node.size() > 0) begin
                    best = 0;
                    for (int i = 1; i < fifo_node.size(); i++) begin
                        if (heur_of[fifo_node[i]] < heur_of[fifo_node[best]] ||
                            (heur_of[fifo_node[i]] == heur_of[fifo_node[best]] &&
                             fifo_seq[i] < fifo_seq[best]))
                            best = i;
                    end
                    cur = fifo_node[best];
                    fifo_node.delete(best);
                    fifo_seq.delete(best);
                    if (expanded[cur] < 3) expanded[cur]++;
                    if (cur == r.goal) break;
                    e = first_arc[cur];
                    steps = 0;
                    while (e < ECAP && steps < ECAP) begin
                        d = arc_dst[e];
                        if (!has_parent[d]) begin
                            has_parent[d] = 1;
                            parent[d] = cur;
                            reach[d] = sat_sum(reach[cur], arc_wt[e]);
                            if (fifo_node.size() < NODES + 1) begin
                                fifo_node = {fifo_node, d};
                                fifo_seq = {fifo_seq, seqn};
                                seqn++;
                            end
                        end
                        e = arc_next[e];
                        steps++;
                    end
                end
                if (!has_parent[r.goal]) begin
                    item = '{KIND_NOPATH, '0, 32'hffffffff, '0, 1'b0};
                    res = {res, item};
                end else begin
                    cur = r.goal;
                    len = 0;
                    while (cur != r.start && len < NODES - 1) begin
                        route.push_front(cur);
                        cur = parent[cur];
                        len++;
                    end
                    route.push_front(r.start);
                    foreach (route[i]) begin
                        item = '{KIND_PATH, ID_W'(route[i]), reach[r.goal], '0, 1'b0};
                        res = {res, item};
                    end
                end
                for (k = 0; k < NODES; k++)
                    if (expanded[k] > 0) begin
                        item = '{KIND_COUNT, ID_W'(k), '0, CNT_W'(expanded[k]), 1'b0};
                        res = {res, item};
                    end
                res[res.size()-1].last = 1'b1;
                foreach (res[i]) expected_results = {expected_results, res[i]};
            end
            default: ;
        endcase
    endtask

    function automatic t_request mk_heur(int v, int h);
        t_request r;
        r = '{REQ_HEUR, ID_W'(v), HEUR_W'(h), ID_W'($urandom), ID_W'($urandom),
              WEIGHT_W'($urandom), ID_W'($urandom), ID_W'($urandom)};
        return r;
    endfunction

    function automatic t_request mk_edge(int f, int t, int c);
        t_request r;
        r = '{REQ_EDGE, ID_W'($urandom), HEUR_W'($urandom), ID_W'(f), ID_W'(t),
              WEIGHT_W'(c), ID_W'($urandom), ID_W'($urandom)};
        return r;
    endfunction

    function automatic t_request mk_search(int s, int g);
        t_request r;
        r = '{REQ_SEARCH, ID_W'($urandom), HEUR_W'($urandom), ID_W'($urandom),
              ID_W'($urandom), WEIGHT_W'($urandom), ID_W'(s), ID_W'(g)};
        return r;
    endfunction

    // clock
    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // stimulus plan: directed graph pieces first, then random graphs and searches
    initial begin
        t_request r;
        int n;
        foreach (first_arc[i]) begin
            first_arc[i] = NO_LINK;
            last_arc[i] = 0;
            heur_of[i] = 0;
        end
        arc_total = 0;
        // search on empty graph, start equals goal, unreachable goal
        add_req(mk_search(0, 0));
        add_req(mk_search(31, 5));
        // extreme heuristics and costs, chain of extreme edge costs
        add_req(mk_heur(31, -32768));
        add_req(mk_heur(0, 32767));
        add_req(mk_heur(1, 32767));
        add_req(mk_edge(0, 1, 32767));
        add_req(mk_edge(1, 2, 32767));
        add_req(mk_edge(2, 31, -32768));
        add_req(mk_edge(0, 31, 1));
        // cycle back to start gives it a predecessor
        add_req(mk_edge(31, 0, -1));
        add_req(mk_search(0, 31));
        add_req(mk_search(0, 2));
        add_req(mk_search(0, 0));
        // unused request code is ignored
        r = mk_search(3, 4);
        r.req = REQ_NONE;
        add_req(r);
        add_req(mk_heur(2, -5));
        add_req(mk_search(1, 31));
        // random phase: heuristics on any node, edges on few nodes, then searches
        while (pending_reqs.size() < 85) begin
            n = $urandom_range(3, 12);
            for (int i = 0; i < $urandom_range(1, 6); i++)
                add_req(mk_heur($urandom_range(0, 31),
                    ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 20)));
            for (int i = 0; i < $urandom_range(2, 10); i++)
                add_req(mk_edge($urandom_range(0, n), $urandom_range(0, n),
                    ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 50)));
            for (int i = 0; i < $urandom_range(1, 3); i++)
                add_req(mk_search($urandom_range(0, n),
                    ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(0, n)));
            if ($urandom_range(0, 9) == 0) begin
                r = mk_search(0, 0);
                r.req = REQ_NONE;
                add_req(r);
            end
        end
        add_req(mk_search($urandom_range(0, 31), $urandom_range(0, 31)));
        add_req(mk_search(0, 31));
        add_req(mk_search(5, 9));
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            tx_gap <= 0;
        end else if (!i_valid || o_ready) begin
            // current request (if any) taken this edge
            if (i_valid) begin
                predict_request(pending_reqs.pop_front());
                requests_sent++;
            end
            if (tx_gap > 0) begin
                tx_gap <= tx_gap - 1;
                i_valid <= 1'b0;
            end else if (i_valid && !quiet_phase && $urandom_range(0, 5) == 0) begin
                tx_gap <= $urandom_range(0, 4);
                i_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                r_drive(pending_reqs[0]);
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    task automatic r_drive(t_request r);
        i_req_type        <= r.req;
        i_vertex_id       <= r.vertex;
        i_heuristic_value <= r.heur;
        i_edge_from       <= r.efrom;
        i_edge_to         <= r.eto;
        i_edge_cost       <= r.ecost;
        i_start_node      <= r.start;
        i_goal_node       <= r.goal;
        if (r.req == REQ_SEARCH) searches_sent++;
    endtask

    // receiver: random stall bursts, one long hold-off early on
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            rx_gap <= 0;
        end else if (hold_rx) begin
            i_ready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap <= rx_gap - 1;
            i_ready <= 1'b0;
        end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
            rx_gap <= $urandom_range(0, 4);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // monitor: compare each result with the oldest expected one
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                $error("unexpected result kind=%0d node=%0d", o_item_kind, o_node_ref);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                if (o_item_kind !== want.kind) begin
                    $error("item_kind exp %0d got %0d", want.kind, o_item_kind);
                    mismatches++;
                end
                if (o_node_ref !== want.node) begin
                    $error("node_ref exp %0d got %0d", want.node, o_node_ref);
                    mismatches++;
                end
                if (o_path_cost !== want.cost) begin
                    $error("path_cost exp %0d got %0d", $signed(want.cost), o_path_cost);
                    mismatches++;
                end
                if (o_expand_count !== want.cnt) begin
                    $error("expand_count exp %0d got %0d", want.cnt, o_expand_count);
                    mismatches++;
                end
                if (o_last_item !== want.last) begin
                    $error("last_item exp %0d got %0d", want.last, o_last_item);
                    mismatches++;
                end
            end
        end
    end

    // reset, long receiver hold-off, quiet tail, end of run
    initial begin
        int cnt;
        mismatches = 0;
        requests_sent = 0;
        results_seen = 0;
        searches_sent = 0;
        quiet_phase = 0;
        hold_rx = 0;
        i_rst_n = 0;
        i_valid = 0;
        i_ready = 0;
        i_req_type = '0;
        i_vertex_id = '0;
        i_heuristic_value = '0;
        i_edge_from = '0;
        i_edge_to = '0;
        i_edge_cost = '0;
        i_start_node = '0;
        i_goal_node = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        // hold results back while the sender keeps offering requests
        wait (requests_sent >= 11);
        hold_rx = 1;
        cnt = 0;
        while (cnt < 3000) begin
            @(posedge i_clk);
            cnt++;
        end
        hold_rx = 0;
        wait (pending_reqs.size() < 40);
        quiet_phase = 1;
        wait (pending_reqs.size() == 0 && !i_valid);
        wait (expected_results.size() == 0);
        repeat (3000) @(posedge i_clk);
        $display("sent %0d requests, %0d searches; checked %0d results",
                 requests_sent, searches_sent, results_seen);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // watchdog
    initial begin
        #20000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

### filelist.f
design/gbfs_pkg.sv
design/gbfs_ctrl.sv
design/gbfs_dp.sv
design/greedy_best_first_search.sv
tb/tb_top.sv
